// ===== sv/swept_box_collision_test_unit_macros.svh =====
// Assertion macros for the swept box collision test unit.
// Used by the port checker; needs a clock named clk and a reset named rst in scope.
`ifndef SWEPT_BOX_COLLISION_TEST_UNIT_MACROS_SVH
`define SWEPT_BOX_COLLISION_TEST_UNIT_MACROS_SVH

// Property checked outside reset.
`define SBCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define SBCT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/sbct_pkg.sv =====
// Shared constants and types for the swept box collision test unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sbct_pkg;

  // Default geometry and time formats.
  localparam int DEF_COORD_WIDTH    = 32;
  localparam int DEF_TIME_FRAC_BITS = 16;

  // Times are always signed 32-bit words; the limit is 31 bits unsigned.
  localparam int TIME_W  = 32;
  localparam int LIMIT_W = 31;

  localparam logic [TIME_W-1:0] TIME_MAX     = {1'b0, {(TIME_W-1){1'b1}}};
  localparam logic [TIME_W-1:0] TIME_MIN     = {1'b1, {(TIME_W-1){1'b0}}};
  localparam logic [TIME_W-1:0] NEG_MAG_LIM  = {1'b1, {(TIME_W-1){1'b0}}};

  // Divider lane latency: operand stage, setup stage, one stage per quotient bit, output stage.
  localparam int DIV_LAT = TIME_W + 3;

  // Normal codes.
  localparam logic [1:0] NORM_NONE = 2'b00;
  localparam logic [1:0] NORM_POS  = 2'b01;
  localparam logic [1:0] NORM_NEG  = 2'b11;

  // Per-word data that rides alongside the divider lanes.
  typedef struct packed {
    logic               dxe_neg;
    logic               dye_neg;
    logic [LIMIT_W-1:0] limit;
  } sbct_side_t;

  // One result word.
  typedef struct packed {
    logic              hit;
    logic [TIME_W-1:0] contact_time;
    logic [1:0]        normal_x;
    logic [1:0]        normal_y;
  } sbct_result_t;

endpackage

// ===== sv/sbct_fifo.sv =====
// Two-entry first-in first-out queue used between the front and back and at the output.
// Depends on sbct_pkg only by convention; generic in data width.
`timescale 1ns / 1ps

module sbct_fifo import sbct_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] mem [0:1];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;
  logic         do_wr;
  logic         do_rd;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_wr) wptr <= !wptr;
      if (do_rd) rptr <= !rptr;
      count <= count + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_wr) mem[wptr] <= wdata;
  end

endmodule

// ===== sv/sbct_front.sv =====
// Front part: input register and per-axis entry and exit distances.
// Depends on sbct_pkg.
`timescale 1ns / 1ps

module sbct_front import sbct_pkg::*; #(
  parameter int CW = DEF_COORD_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic signed [CW-1:0]  mover_x,
  input  logic signed [CW-1:0]  mover_y,
  input  logic [CW-2:0]         mover_width,
  input  logic [CW-2:0]         mover_height,
  input  logic signed [CW-1:0]  velocity_x,
  input  logic signed [CW-1:0]  velocity_y,
  input  logic signed [CW-1:0]  obstacle_x,
  input  logic signed [CW-1:0]  obstacle_y,
  input  logic [CW-2:0]         obstacle_width,
  input  logic [CW-2:0]         obstacle_height,
  input  logic [LIMIT_W-1:0]    time_limit,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [CW+1:0]  dxe,
  output logic signed [CW+1:0]  dxx,
  output logic signed [CW+1:0]  dye,
  output logic signed [CW+1:0]  dyx,
  output logic signed [CW-1:0]  vx,
  output logic signed [CW-1:0]  vy,
  output logic [LIMIT_W-1:0]    limit
);

  localparam int DW = CW + 2;

  logic                 fv;
  logic                 adv;
  logic signed [CW-1:0] mx, my, ox, oy;
  logic [CW-2:0]        mw, mh, ow, oh;
  logic signed [DW-1:0] mx_far, my_far, ox_far, oy_far;
  logic signed [DW-1:0] mx_e, my_e, ox_e, oy_e;
  logic                 vx_pos, vy_pos;

  assign adv       = !fv || out_ready;
  assign full      = !adv;
  assign out_valid = fv;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (adv) begin
      fv <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && push) begin
      mx    <= mover_x;
      my    <= mover_y;
      mw    <= mover_width;
      mh    <= mover_height;
      vx    <= velocity_x;
      vy    <= velocity_y;
      ox    <= obstacle_x;
      oy    <= obstacle_y;
      ow    <= obstacle_width;
      oh    <= obstacle_height;
      limit <= time_limit;
    end
  end

  // Near and far edges, widened so that no sum overflows.
  assign mx_e   = DW'(mx);
  assign my_e   = DW'(my);
  assign ox_e   = DW'(ox);
  assign oy_e   = DW'(oy);
  assign mx_far = mx_e + $signed({3'b000, mw});
  assign my_far = my_e + $signed({3'b000, mh});
  assign ox_far = ox_e + $signed({3'b000, ow});
  assign oy_far = oy_e + $signed({3'b000, oh});

  // A zero velocity counts as moving left or down.
  assign vx_pos = !vx[CW-1] && (vx != '0);
  assign vy_pos = !vy[CW-1] && (vy != '0);

  // The direction of motion picks the leading and trailing edges.
  always_comb begin
    if (vx_pos) begin
      dxe = ox_e - mx_far;
      dxx = ox_far - mx_e;
    end else begin
      dxe = ox_far - mx_e;
      dxx = ox_e - mx_far;
    end
    if (vy_pos) begin
      dye = oy_e - my_far;
      dyx = oy_far - my_e;
    end else begin
      dye = oy_far - my_e;
      dyx = oy_e - my_far;
    end
  end

endmodule

// ===== sv/sbct_div.sv =====
// Pipelined divider lane: distance * 2^TF / velocity, truncated and saturated.
// Depends on sbct_pkg; one quotient bit per stage, all stages move on a shared enable.
`timescale 1ns / 1ps

module sbct_div import sbct_pkg::*; #(
  parameter int CW = DEF_COORD_WIDTH,
  parameter int TF = DEF_TIME_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [CW+1:0]     num,
  input  logic signed [CW-1:0]     den,
  output logic signed [TIME_W-1:0] quot
);

  localparam int DW = CW + 2;
  localparam int AW = CW + 1;
  localparam int NW = AW + TF;
  localparam int XW = NW + 1;

  // Operand stage.
  logic          a_neg;
  logic          a_zz;
  logic [AW-1:0] a_mag;
  logic [CW-1:0] a_div;

  // Setup values.
  logic [XW-1:0]     n_ext;
  logic [XW-1:0]     n_high;
  logic              b_ovf;

  // Quotient bit stages.
  logic [CW-1:0]     rem  [0:TIME_W];
  logic [TIME_W-1:0] low  [0:TIME_W];
  logic [TIME_W-1:0] quo  [0:TIME_W];
  logic [CW-1:0]     dv   [0:TIME_W];
  logic              neg  [0:TIME_W];
  logic              zz   [0:TIME_W];
  logic              ovf  [0:TIME_W];
  logic [CW:0]       trial [0:TIME_W-1];
  logic [CW:0]       diff  [0:TIME_W-1];
  logic              take  [0:TIME_W-1];

  logic [TIME_W-1:0] q_fin;
  logic              q_big;

  // Signs and magnitudes.
  always_ff @(posedge clk) begin
    if (en) begin
      a_neg <= num[DW-1] ^ den[CW-1];
      a_zz  <= (num == '0) && (den == '0);
      a_mag <= AW'(num[DW-1] ? -num : num);
      a_div <= den[CW-1] ? -den : den;
    end
  end

  // The part of the dividend above the kept quotient bits must be below the divisor.
  assign n_ext  = XW'(a_mag) << TF;
  assign n_high = n_ext >> TIME_W;
  assign b_ovf  = (n_high >= XW'(a_div));

  // Restoring division step per stage.
  always_comb begin
    for (int i = 0; i < TIME_W; i++) begin
      trial[i] = {rem[i], low[i][TIME_W-1]};
      take[i]  = (trial[i] >= {1'b0, dv[i]});
      diff[i]  = trial[i] - {1'b0, dv[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= CW'(n_high);
      low[0] <= TIME_W'(n_ext);
      quo[0] <= '0;
      dv[0]  <= a_div;
      neg[0] <= a_neg;
      zz[0]  <= a_zz;
      ovf[0] <= b_ovf;
      for (int i = 0; i < TIME_W; i++) begin
        rem[i+1] <= take[i] ? CW'(diff[i]) : CW'(trial[i]);
        low[i+1] <= low[i] << 1;
        quo[i+1] <= {quo[i][TIME_W-2:0], take[i]};
        dv[i+1]  <= dv[i];
        neg[i+1] <= neg[i];
        zz[i+1]  <= zz[i];
        ovf[i+1] <= ovf[i];
      end
    end
  end

  // Saturation and sign.
  assign q_fin = quo[TIME_W];
  assign q_big = ovf[TIME_W] ||
                 (neg[TIME_W] ? (q_fin > NEG_MAG_LIM) : q_fin[TIME_W-1]);

  always_ff @(posedge clk) begin
    if (en) begin
      if (zz[TIME_W]) begin
        quot <= TIME_MIN;
      end else if (q_big) begin
        quot <= neg[TIME_W] ? TIME_MIN : TIME_MAX;
      end else begin
        quot <= neg[TIME_W] ? -q_fin : q_fin;
      end
    end
  end

endmodule

// ===== sv/sbct_resolve.sv =====
// Hit decision, contact time and normal from the four axis times.
// Depends on sbct_pkg.
`timescale 1ns / 1ps

module sbct_resolve import sbct_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [TIME_W-1:0] txe,
  input  logic signed [TIME_W-1:0] txx,
  input  logic signed [TIME_W-1:0] tye,
  input  logic signed [TIME_W-1:0] tyx,
  input  sbct_side_t               side,
  output sbct_result_t             res
);

  logic signed [TIME_W-1:0] t_in;
  logic signed [TIME_W-1:0] t_out;
  logic signed [TIME_W-1:0] lim;
  logic                     x_later;
  logic                     miss;
  sbct_result_t             res_next;

  assign lim     = $signed({1'b0, side.limit});
  assign x_later = (txe > tye);
  assign t_in    = x_later ? txe : tye;
  assign t_out   = (txx < tyx) ? txx : tyx;
  assign miss    = (t_in > t_out) || (txe[TIME_W-1] && tye[TIME_W-1]) ||
                   (txe > lim) || (tye > lim);

  // The normal goes on the axis that enters later, vertical on a tie.
  always_comb begin
    res_next = '0;
    if (!miss) begin
      res_next.hit          = 1'b1;
      res_next.contact_time = t_in;
      if (x_later) begin
        res_next.normal_x = side.dxe_neg ? NORM_POS : NORM_NEG;
      end else begin
        res_next.normal_y = side.dye_neg ? NORM_POS : NORM_NEG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) res <= res_next;
  end

endmodule

// ===== sv/swept_box_collision_test_unit.sv =====
// Swept axis-aligned box collision test unit.
// Input side is a queue: present a word with push while full is low; one word per cycle.
// Result side is a queue: while empty is low the oldest result is on hit, contact_time,
// normal_x and normal_y; pop takes it. Every input word gives exactly one result word.
// An accepted word passes the input register, the middle queue, DIV_LAT divider stages and the
// decision stage, and then enters the result queue before its result shows.
// Throughput is one word per cycle while the back does not stall; four divider lanes, one
// per axis time, each produce one quotient bit per stage.
// A two-word queue separates the front (input register and distance sums) from the back
// (divider lanes and decision), and a two-word queue holds finished results.
// When the receiver stops popping, the back stalls as a whole once the result queue
// fills, then the middle queue fills and full rises; nothing is lost.
// Synchronous reset empties both queues and clears all valid flags; no clearing pass.
// Depends on sbct_pkg, sbct_front, sbct_fifo, sbct_div and sbct_resolve.
`timescale 1ns / 1ps

module swept_box_collision_test_unit import sbct_pkg::*; #(
  parameter int COORD_WIDTH    = DEF_COORD_WIDTH,
  parameter int TIME_FRAC_BITS = DEF_TIME_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic signed [COORD_WIDTH-1:0]  mover_x,
  input  logic signed [COORD_WIDTH-1:0]  mover_y,
  input  logic [COORD_WIDTH-2:0]         mover_width,
  input  logic [COORD_WIDTH-2:0]         mover_height,
  input  logic signed [COORD_WIDTH-1:0]  velocity_x,
  input  logic signed [COORD_WIDTH-1:0]  velocity_y,
  input  logic signed [COORD_WIDTH-1:0]  obstacle_x,
  input  logic signed [COORD_WIDTH-1:0]  obstacle_y,
  input  logic [COORD_WIDTH-2:0]         obstacle_width,
  input  logic [COORD_WIDTH-2:0]         obstacle_height,
  input  logic [LIMIT_W-1:0]             time_limit,
  input  logic                           pop,
  output logic                           empty,
  output logic                           hit,
  output logic signed [TIME_W-1:0]       contact_time,
  output logic signed [1:0]              normal_x,
  output logic signed [1:0]              normal_y
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 2;
  localparam int MW = 4 * DW + 2 * CW + LIMIT_W;
  localparam int RW = $bits(sbct_result_t);

  // Front to middle queue.
  logic                 f_valid;
  logic                 mid_full;
  logic                 mid_empty;
  logic signed [DW-1:0] f_dxe, f_dxx, f_dye, f_dyx;
  logic signed [CW-1:0] f_vx, f_vy;
  logic [LIMIT_W-1:0]   f_limit;
  logic [MW-1:0]        mid_wdata;
  logic [MW-1:0]        mid_rdata;

  // Back part.
  logic signed [DW-1:0]     b_dxe, b_dxx, b_dye, b_dyx;
  logic signed [CW-1:0]     b_vx, b_vy;
  logic [LIMIT_W-1:0]       b_limit;
  logic                     en;
  logic                     vld  [0:DIV_LAT];
  sbct_side_t               side [0:DIV_LAT-1];
  sbct_side_t               head_side;
  logic signed [TIME_W-1:0] txe, txx, tye, tyx;
  sbct_result_t             res;
  logic                     out_full;
  logic [RW-1:0]            out_rdata;
  sbct_result_t             out_word;

  sbct_front #(.CW(CW)) u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .mover_x         (mover_x),
    .mover_y         (mover_y),
    .mover_width     (mover_width),
    .mover_height    (mover_height),
    .velocity_x      (velocity_x),
    .velocity_y      (velocity_y),
    .obstacle_x      (obstacle_x),
    .obstacle_y      (obstacle_y),
    .obstacle_width  (obstacle_width),
    .obstacle_height (obstacle_height),
    .time_limit      (time_limit),
    .out_valid       (f_valid),
    .out_ready       (!mid_full),
    .dxe             (f_dxe),
    .dxx             (f_dxx),
    .dye             (f_dye),
    .dyx             (f_dyx),
    .vx              (f_vx),
    .vy              (f_vy),
    .limit           (f_limit)
  );

  assign mid_wdata = {f_dxe, f_dxx, f_dye, f_dyx, f_vx, f_vy, f_limit};

  sbct_fifo #(.W(MW)) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (f_valid),
    .wdata (mid_wdata),
    .rd    (en),
    .rdata (mid_rdata),
    .full  (mid_full),
    .empty (mid_empty)
  );

  assign {b_dxe, b_dxx, b_dye, b_dyx, b_vx, b_vy, b_limit} = mid_rdata;

  // The whole back moves together unless the finished word cannot leave.
  assign en = !vld[DIV_LAT] || !out_full;

  assign head_side.dxe_neg = b_dxe[DW-1];
  assign head_side.dye_neg = b_dye[DW-1];
  assign head_side.limit   = b_limit;

  // Valid flags along the back.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= DIV_LAT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= !mid_empty;
      for (int i = 1; i <= DIV_LAT; i++) vld[i] <= vld[i-1];
    end
  end

  // Side data travels next to the divider lanes.
  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= head_side;
      for (int i = 1; i < DIV_LAT; i++) side[i] <= side[i-1];
    end
  end

  sbct_div #(.CW(CW), .TF(TIME_FRAC_BITS)) u_div_xe (
    .clk (clk), .en (en), .num (b_dxe), .den (b_vx), .quot (txe)
  );

  sbct_div #(.CW(CW), .TF(TIME_FRAC_BITS)) u_div_xx (
    .clk (clk), .en (en), .num (b_dxx), .den (b_vx), .quot (txx)
  );

  sbct_div #(.CW(CW), .TF(TIME_FRAC_BITS)) u_div_ye (
    .clk (clk), .en (en), .num (b_dye), .den (b_vy), .quot (tye)
  );

  sbct_div #(.CW(CW), .TF(TIME_FRAC_BITS)) u_div_yx (
    .clk (clk), .en (en), .num (b_dyx), .den (b_vy), .quot (tyx)
  );

  sbct_resolve u_resolve (
    .clk  (clk),
    .en   (en),
    .txe  (txe),
    .txx  (txx),
    .tye  (tye),
    .tyx  (tyx),
    .side (side[DIV_LAT-1]),
    .res  (res)
  );

  sbct_fifo #(.W(RW)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (vld[DIV_LAT]),
    .wdata (res),
    .rd    (pop),
    .rdata (out_rdata),
    .full  (out_full),
    .empty (empty)
  );

  // Result ports.
  assign out_word     = out_rdata;
  assign hit          = out_word.hit;
  assign contact_time = out_word.contact_time;
  assign normal_x     = out_word.normal_x;
  assign normal_y     = out_word.normal_y;

endmodule

// ===== sv/sbct_checker.sv =====
// Port-level checker for the swept box collision test unit, bound to the top level.
// Depends on swept_box_collision_test_unit_macros.svh and the top level's port names.
`timescale 1ns / 1ps
`include "swept_box_collision_test_unit_macros.svh"

module sbct_checker import sbct_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              push,
  input logic              full,
  input logic              pop,
  input logic              empty,
  input logic              hit,
  input logic [TIME_W-1:0] contact_time,
  input logic [1:0]        normal_x,
  input logic [1:0]        normal_y
);

  // A miss carries no time and no normal.
  `SBCT_ASSERT(a_miss_clean, (!empty && !hit) |-> (contact_time == '0 && normal_x == NORM_NONE && normal_y == NORM_NONE), "miss word has nonzero fields")

  // A hit has exactly one nonzero normal component.
  `SBCT_ASSERT(a_hit_one_normal, (!empty && hit) |-> ((normal_x != NORM_NONE) != (normal_y != NORM_NONE)), "hit word normal is not on exactly one axis")

  // A hit never enters at a negative time.
  `SBCT_ASSERT(a_hit_time_pos, (!empty && hit) |-> !contact_time[TIME_W-1], "hit word has negative contact time")

  // No result is left over after a reset cycle.
  `SBCT_ASSERT_ALWAYS(a_reset_empty, rst |=> empty, "result queue not empty after reset")

endmodule

bind swept_box_collision_test_unit sbct_checker u_sbct_checker (.*);

// ===== dv/tb_swept_box_collision_test_unit.sv =====
// Self-checking testbench for the swept box collision test unit.
// Needs sbct_pkg and the RTL of swept_box_collision_test_unit; reads no files.
`timescale 1ns / 1ps

module tb_swept_box_collision_test_unit;
  import sbct_pkg::*;

  localparam int CW = DEF_COORD_WIDTH;
  localparam int TFB = DEF_TIME_FRAC_BITS;
  localparam int RESULT_LAT = DIV_LAT + 3;
  localparam longint T_HI = 64'sd2147483647;
  localparam longint T_LO = -64'sd2147483648;

  // One input word: a moving box, a still box and a look-ahead limit.
  typedef struct {
    logic signed [CW-1:0] mx, my;
    logic [CW-2:0]        mw, mh;
    logic signed [CW-1:0] vx, vy, ox, oy;
    logic [CW-2:0]        ow, oh;
    logic [LIMIT_W-1:0]   lim;
  } box_pair_t;

  // A directed row; the result is typed in only when it is plain to see.
  typedef struct {
    box_pair_t    word;
    bit           typed;
    sbct_result_t want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty, hit;
  logic signed [CW-1:0] mover_x = '0, mover_y = '0, velocity_x = '0, velocity_y = '0;
  logic signed [CW-1:0] obstacle_x = '0, obstacle_y = '0;
  logic [CW-2:0] mover_width = '0, mover_height = '0;
  logic [CW-2:0] obstacle_width = '0, obstacle_height = '0;
  logic [LIMIT_W-1:0] time_limit = '0;
  logic signed [TIME_W-1:0] contact_time;
  logic signed [1:0] normal_x, normal_y;

  sbct_result_t pending_results[$];
  int mismatches = 0;
  int words_sent = 0;
  int results_seen = 0;
  int hits_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  swept_box_collision_test_unit u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .mover_x(mover_x), .mover_y(mover_y),
    .mover_width(mover_width), .mover_height(mover_height),
    .velocity_x(velocity_x), .velocity_y(velocity_y),
    .obstacle_x(obstacle_x), .obstacle_y(obstacle_y),
    .obstacle_width(obstacle_width), .obstacle_height(obstacle_height),
    .time_limit(time_limit), .pop(pop), .empty(empty), .hit(hit),
    .contact_time(contact_time), .normal_x(normal_x), .normal_y(normal_y)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Distance over speed as a 16.16 time, truncated toward zero and clamped.
  function automatic longint travel_time(longint gap, longint speed);
    bit neg;
    longint unsigned a, b, q, r, lim;
    if (speed == 0) begin
      return (gap > 0) ? T_HI : T_LO;
    end
    neg = (gap < 0) != (speed < 0);
    a = (gap < 0) ? -gap : gap;
    b = (speed < 0) ? -speed : speed;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    q = a / b;
    r = a % b;
    if (q > lim) return neg ? T_LO : T_HI;
    for (int i = 0; i < TFB; i++) begin
      q = q << 1;
      r = r << 1;
      if (r >= b) begin
        q = q + 1;
        r = r - b;
      end
      if (q > lim) return neg ? T_LO : T_HI;
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  // Entry and exit times per axis, then the hit decision and the contact normal.
  function automatic sbct_result_t predict_contact(box_pair_t w);
    longint mx, my, mw, mh, vx, vy, ox, oy, ow, oh, lim;
    longint dxe, dxx, dye, dyx, txe, txx, tye, tyx, t_in, t_out;
    sbct_result_t res;
    mx = w.mx; my = w.my; vx = w.vx; vy = w.vy; ox = w.ox; oy = w.oy;
    mw = longint'({1'b0, w.mw}); mh = longint'({1'b0, w.mh});
    ow = longint'({1'b0, w.ow}); oh = longint'({1'b0, w.oh});
    lim = longint'({1'b0, w.lim});
    if (vx > 0) begin
      dxe = ox - (mx + mw);
      dxx = (ox + ow) - mx;
    end else begin
      dxe = (ox + ow) - mx;
      dxx = ox - (mx + mw);
    end
    if (vy > 0) begin
      dye = oy - (my + mh);
      dyx = (oy + oh) - my;
    end else begin
      dye = (oy + oh) - my;
      dyx = oy - (my + mh);
    end
    txe = travel_time(dxe, vx);
    txx = travel_time(dxx, vx);
    tye = travel_time(dye, vy);
    tyx = travel_time(dyx, vy);
    t_in = (txe > tye) ? txe : tye;
    t_out = (txx < tyx) ? txx : tyx;
    res = '0;
    if (t_in > t_out || (txe < 0 && tye < 0) || txe > lim || tye > lim) return res;
    res.hit = 1'b1;
    res.contact_time = t_in[TIME_W-1:0];
    res.normal_x = NORM_NONE;
    res.normal_y = NORM_NONE;
    if (txe > tye) res.normal_x = (dxe < 0) ? NORM_POS : NORM_NEG;
    else res.normal_y = (dye < 0) ? NORM_POS : NORM_NEG;
    return res;
  endfunction

  function automatic box_pair_t pair_of(longint mx, longint my, longint mw, longint mh,
                                        longint vx, longint vy, longint ox, longint oy,
                                        longint ow, longint oh, longint lim);
    box_pair_t w;
    w.mx = CW'(mx); w.my = CW'(my); w.mw = (CW-1)'(mw); w.mh = (CW-1)'(mh);
    w.vx = CW'(vx); w.vy = CW'(vy);
    w.ox = CW'(ox); w.oy = CW'(oy); w.ow = (CW-1)'(ow); w.oh = (CW-1)'(oh);
    w.lim = LIMIT_W'(lim);
    return w;
  endfunction

  // Either a plausible near-miss or near-hit scene, or raw noise over every bit.
  function automatic box_pair_t random_pair();
    box_pair_t w;
    longint one;
    one = 64'sd1 << 24;
    if ($urandom_range(99) < 20) begin
      w.mx = $urandom; w.my = $urandom; w.mw = (CW-1)'($urandom); w.mh = (CW-1)'($urandom);
      w.vx = $urandom; w.vy = $urandom; w.ox = $urandom; w.oy = $urandom;
      w.ow = (CW-1)'($urandom); w.oh = (CW-1)'($urandom); w.lim = LIMIT_W'($urandom);
      return w;
    end
    w.mx = CW'(longint'($urandom_range(0, 8 << 24)) - 4 * one);
    w.my = CW'(longint'($urandom_range(0, 8 << 24)) - 4 * one);
    w.ox = CW'(longint'($urandom_range(0, 8 << 24)) - 4 * one);
    w.oy = CW'(longint'($urandom_range(0, 8 << 24)) - 4 * one);
    w.mw = (CW-1)'($urandom_range(0, 2 << 24));
    w.mh = (CW-1)'($urandom_range(0, 2 << 24));
    w.ow = (CW-1)'($urandom_range(0, 2 << 24));
    w.oh = (CW-1)'($urandom_range(0, 2 << 24));
    w.vx = CW'(($urandom_range(9) == 0) ? 0 :
               longint'($urandom_range(0, 4 << 24)) - 2 * one);
    w.vy = CW'(($urandom_range(9) == 0) ? 0 :
               longint'($urandom_range(0, 4 << 24)) - 2 * one);
    w.lim = ($urandom_range(7) == 0) ? LIMIT_W'($urandom) :
                                       LIMIT_W'($urandom_range(0, 16 << 16));
    return w;
  endfunction

  // Present one word and hold it until the block takes it; then idle cycle by cycle.
  task automatic send_word(box_pair_t w, sbct_result_t want);
    mover_x <= w.mx; mover_y <= w.my; mover_width <= w.mw; mover_height <= w.mh;
    velocity_x <= w.vx; velocity_y <= w.vy; obstacle_x <= w.ox; obstacle_y <= w.oy;
    obstacle_width <= w.ow; obstacle_height <= w.oh; time_limit <= w.lim;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_results.push_back(want);
    words_sent++;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // The receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare every popped result word with the oldest expectation.
  always @(posedge clk) begin
    sbct_result_t want;
    if (!rst && pop && !empty) begin
      results_seen++;
      if (hit) hits_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word: hit=%0b time=%0d", hit,
                                       contact_time);
      end else begin
        want = pending_results.pop_front();
        if (hit !== want.hit || contact_time !== want.contact_time ||
            normal_x !== want.normal_x || normal_y !== want.normal_y) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected hit=%0b t=%0d n=(%0d,%0d), got hit=%0b t=%0d n=(%0d,%0d)",
                     want.hit, $signed(want.contact_time), $signed(want.normal_x),
                     $signed(want.normal_y), hit, contact_time, normal_x, normal_y);
        end
      end
    end
  end

  // Main sequence: reset, directed table, then four idling phases of random words.
  initial begin
    directed_row_t rows[$];
    directed_row_t row;
    sbct_result_t miss;
    longint one;
    int idle_pct[4];
    int stall_pct[4];
    int phase_words[4];
    idle_pct = '{0, 47, 0, 15};
    stall_pct = '{0, 0, 47, 15};
    phase_words = '{360, 360, 360, 370};
    one = 64'sd1 << 24;
    miss = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Everything zero: zero over zero gives the most negative entries, so a miss.
    row.typed = 1; row.want = miss;
    row.word = pair_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    rows.push_back(row);
    // Overlapping but still: entries saturate high and exits low, so a miss.
    row.word = pair_of(0, 0, one, one, 0, 0, 0, 0, one, one, 32'h7fffffff);
    rows.push_back(row);
    row.typed = 0;
    // Field extremes.
    row.word = pair_of(32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff, 31'h7fffffff,
                       32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                       31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
    rows.push_back(row);
    row.word = pair_of(-64'sd2147483648, -64'sd2147483648, 0, 0, -64'sd2147483648,
                       -64'sd2147483648, -64'sd2147483648, -64'sd2147483648, 0, 0, 0);
    rows.push_back(row);
    row.word = pair_of(-64'sd2147483648, 0, 31'h7fffffff, 0, 32'sh7fffffff, 1,
                       32'sh7fffffff, 0, 31'h7fffffff, one, 31'h7fffffff);
    rows.push_back(row);
    // Head-on along x, then along y, then both directions reversed.
    row.word = pair_of(0, 0, one, one, one, 1, 2 * one, 0, one, one, 4 << 16);
    rows.push_back(row);
    row.word = pair_of(0, 0, one, one, 1, one, 0, 2 * one, one, one, 4 << 16);
    rows.push_back(row);
    row.word = pair_of(3 * one, 0, one, one, -one, -1, 0, 0, one, one, 4 << 16);
    rows.push_back(row);
    row.word = pair_of(0, 3 * one, one, one, -1, -one, 0, 0, one, one, 4 << 16);
    rows.push_back(row);
    // Tied entry times on both axes put the normal on the vertical axis.
    row.word = pair_of(0, 0, one, one, one, one, 2 * one, 2 * one, one, one, 4 << 16);
    rows.push_back(row);
    // Contact just beyond the limit, and exactly at it.
    row.word = pair_of(0, 0, one, one, one, 1, 2 * one, 0, one, one, (1 << 16) - 1);
    rows.push_back(row);
    row.word = pair_of(0, 0, one, one, one, 1, 2 * one, 0, one, one, 1 << 16);
    rows.push_back(row);
    // Far distance, tiny speed: the quotient saturates.
    row.word = pair_of(-64'sd2000000000, 0, one, one, 1, 1, 64'sd2000000000, 0, one, one,
                       31'h7fffffff);
    rows.push_back(row);
    // Moving away, and already overlapping while moving.
    row.word = pair_of(0, 0, one, one, -one, 0, 2 * one, 0, one, one, 4 << 16);
    rows.push_back(row);
    row.word = pair_of(0, 0, 2 * one, 2 * one, one, one, one, one, one, one, 4 << 16);
    rows.push_back(row);

    foreach (rows[i]) begin
      send_word(rows[i].word, rows[i].typed ? rows[i].want : predict_contact(rows[i].word));
    end
    drain_results();

    for (int p = 0; p < 4; p++) begin
      box_pair_t w;
      send_idle_pct = idle_pct[p];
      recv_stall_pct = stall_pct[p];
      for (int n = 0; n < phase_words[p]; n++) begin
        w = random_pair();
        send_word(w, predict_contact(w));
      end
      // Hold off the sender until every result of the phase has come out.
      drain_results();
    end

    recv_stall_pct = 0;
    repeat (RESULT_LAT + 10) @(posedge clk);
    $display("Sent %0d words over four idling phases; %0d results checked, %0d of them hits.",
             words_sent, results_seen, hits_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Mismatches: %0d, results still owed: %0d", mismatches,
               pending_results.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #20_000_000;
    $display("Timeout with %0d results still owed", pending_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
